>>> hw/rtl/thermal_packet_min_max_stats_macros.svh
// ----------------------------------------------------------------------------
// Thermal packet min/max statistics: assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef THERMAL_PACKET_MIN_MAX_STATS_MACROS_SVH
`define THERMAL_PACKET_MIN_MAX_STATS_MACROS_SVH

// assert on an explicit clock and active-low reset
`define TPMM_ASSERT_CLK(name, clk_sig, rst_sig, prop) \
  name: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
    else $error("tpmm assertion failed");

// assert on clk / rst_n of the enclosing scope
`define TPMM_ASSERT(name, prop) \
  `TPMM_ASSERT_CLK(name, clk, rst_n, prop)

`endif

>>> hw/rtl/tpmm_pkg.sv
// ----------------------------------------------------------------------------
// tpmm_pkg
// Frame geometry, packet codes and shared types of the thermal packet stats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpmm_pkg;

  localparam int unsigned FRAME_WIDTH  = 32;
  localparam int unsigned FRAME_HEIGHT = 24;
  localparam int unsigned FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned MAX_LEN      = 2 * FRAME_PIXELS;

  localparam int unsigned COL_W = $clog2(FRAME_WIDTH);
  localparam int unsigned ROW_W = $clog2(FRAME_HEIGHT);
  localparam int unsigned IDX_W = $clog2(FRAME_PIXELS + 1);
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  localparam int unsigned CEN_ROW0 = FRAME_HEIGHT / 2 - 1;
  localparam int unsigned CEN_COL0 = FRAME_WIDTH / 2 - 1;

  localparam logic [15:0] SYNC_WORD = 16'h8000;
  localparam logic [15:0] TYPE_MAX  = 16'd3;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_LOG  = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_CMD      = 3'd1;
  localparam logic [2:0] ST_LOG      = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE = 3'd3;
  localparam logic [2:0] ST_BAD_LEN  = 3'd4;

  typedef struct packed {
    logic             clr_centre;
    logic             pix_take;
    logic             pix_first;
    logic [15:0]      pix_val;
    logic [COL_W-1:0] pix_col;
    logic [ROW_W-1:0] pix_row;
    logic             zero_take;
    logic             zero_first;
    logic [COL_W-1:0] zero_col;
    logic [ROW_W-1:0] zero_row;
  } pix_req_t;

  typedef struct packed {
    logic [15:0]      hot_val;
    logic [COL_W-1:0] hot_col;
    logic [ROW_W-1:0] hot_row;
    logic [15:0]      cold_val;
    logic [COL_W-1:0] cold_col;
    logic [ROW_W-1:0] cold_row;
    logic [17:0]      centre;
  } stats_t;

  function automatic logic [2:0] kind_status(input logic [1:0] kind);
    logic [2:0] st;
    unique case (kind)
      KIND_CMD:  st = ST_CMD;
      KIND_DATA: st = ST_DONE;
      KIND_LOG:  st = ST_LOG;
      KIND_RSVD: st = ST_BAD_TYPE;
      default:   st = ST_BAD_TYPE;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tpmm_stats.sv
// ----------------------------------------------------------------------------
// tpmm_stats
// Running max/min with position and centre-pixel sum for one frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpmm_stats (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tpmm_pkg::pix_req_t req,
  output tpmm_pkg::stats_t       stats_nxt
);

  tpmm_pkg::stats_t st_r;
  tpmm_pkg::stats_t st_a;
  tpmm_pkg::stats_t st_b;

  function automatic logic in_centre(input logic [tpmm_pkg::COL_W-1:0] col,
                                     input logic [tpmm_pkg::ROW_W-1:0] row);
    logic row_hit;
    logic col_hit;
    row_hit = (32'(row) == tpmm_pkg::CEN_ROW0) || (32'(row) == tpmm_pkg::CEN_ROW0 + 1);
    col_hit = (32'(col) == tpmm_pkg::CEN_COL0) || (32'(col) == tpmm_pkg::CEN_COL0 + 1);
    return row_hit && col_hit;
  endfunction

  // data pixel first, then the trailing zero pixel
  always_comb begin
    st_a = st_r;
    if (req.clr_centre) begin
      st_a.centre = '0;
    end
    if (req.pix_take) begin
      if (req.pix_first) begin
        st_a.hot_val  = req.pix_val;
        st_a.hot_col  = req.pix_col;
        st_a.hot_row  = req.pix_row;
        st_a.cold_val = req.pix_val;
        st_a.cold_col = req.pix_col;
        st_a.cold_row = req.pix_row;
      end else begin
        if (req.pix_val > st_r.hot_val) begin
          st_a.hot_val = req.pix_val;
          st_a.hot_col = req.pix_col;
          st_a.hot_row = req.pix_row;
        end
        if (req.pix_val < st_r.cold_val) begin
          st_a.cold_val = req.pix_val;
          st_a.cold_col = req.pix_col;
          st_a.cold_row = req.pix_row;
        end
      end
      if (in_centre(req.pix_col, req.pix_row)) begin
        st_a.centre = st_a.centre + {2'b00, req.pix_val};
      end
    end

    st_b = st_a;
    if (req.zero_take) begin
      if (req.zero_first) begin
        st_b.hot_val  = '0;
        st_b.hot_col  = '0;
        st_b.hot_row  = '0;
        st_b.cold_val = '0;
        st_b.cold_col = '0;
        st_b.cold_row = '0;
      end else if (st_a.cold_val != 16'h0000) begin
        st_b.cold_val = '0;
        st_b.cold_col = req.zero_col;
        st_b.cold_row = req.zero_row;
      end
    end
  end

  assign stats_nxt = st_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_b;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/thermal_packet_min_max_stats.sv
// Output: a result appears on the out_ registers in the cycle after the byte
// that ends its packet is accepted.
// Throughput: one byte per cycle; in_ready drops only while a result waits
// in the output register and out_ready is low.
// Reset: synchronous rst_n clears the parser, the counters, the statistics
// and the output valid.
// ----------------------------------------------------------------------------
// thermal_packet_min_max_stats
// Byte-serial packet parser with per-frame max/min and centre-sum tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thermal_packet_min_max_stats (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_max_temp,
  output logic [4:0]       out_max_col,
  output logic [4:0]       out_max_row,
  output logic [15:0]      out_min_temp,
  output logic [4:0]       out_min_col,
  output logic [4:0]       out_min_row,
  output logic [17:0]      out_center_sum
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  localparam int unsigned COL_W = tpmm_pkg::COL_W;
  localparam int unsigned ROW_W = tpmm_pkg::ROW_W;
  localparam int unsigned IDX_W = tpmm_pkg::IDX_W;
  localparam int unsigned LEN_W = tpmm_pkg::LEN_W;

  logic [1:0]       phase_r,   phase_nxt;
  logic [7:0]       low_r,     low_nxt;
  logic             have_r,    have_nxt;
  logic [1:0]       ptype_r,   ptype_nxt;
  logic [LEN_W-1:0] left_r,    left_nxt;
  logic [IDX_W-1:0] idx_r,     idx_nxt;
  logic [COL_W-1:0] col_r,     col_nxt;
  logic [ROW_W-1:0] row_r,     row_nxt;

  logic             ov_r;
  logic [2:0]       status_r;
  tpmm_pkg::stats_t res_r;

  logic             acc;
  logic [15:0]      word;
  logic             is_data;
  logic [LEN_W-1:0] left_dec;
  logic             last;
  logic             idx_lt;
  logic             idx1_lt;
  logic [COL_W-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;
  logic             produce;
  logic [2:0]       res_status;

  tpmm_pkg::pix_req_t req;
  tpmm_pkg::stats_t   st_nxt;

  tpmm_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .stats_nxt (st_nxt)
  );

  assign in_ready = !ov_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign word     = {in_rx_byte, low_r};
  assign is_data  = (ptype_r == tpmm_pkg::KIND_DATA);
  assign left_dec = left_r - 1'b1;
  assign last     = (left_dec == '0);
  assign idx_lt   = (32'(idx_r) < tpmm_pkg::FRAME_PIXELS);
  assign idx1_lt  = (32'(idx_r) + 32'd1 < tpmm_pkg::FRAME_PIXELS);

  always_comb begin
    if (32'(col_r) == tpmm_pkg::FRAME_WIDTH - 1) begin
      col_inc = '0;
      row_inc = row_r + 1'b1;
    end else begin
      col_inc = col_r + 1'b1;
      row_inc = row_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    low_nxt    = low_r;
    have_nxt   = have_r;
    ptype_nxt  = ptype_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    req        = '0;
    produce    = 1'b0;
    res_status = tpmm_pkg::ST_DONE;

    if (acc) begin
      unique case (phase_r)
        PH_BODY: begin
          left_nxt = left_dec;
          if (is_data) begin
            if (!have_r) begin
              low_nxt  = in_rx_byte;
              have_nxt = 1'b1;
            end else begin
              have_nxt = 1'b0;
              idx_nxt  = idx_r + 1'b1;
              col_nxt  = col_inc;
              row_nxt  = row_inc;
            end
          end
          req.pix_take  = is_data && idx_lt && (have_r || last);
          req.pix_first = (idx_r == '0);
          req.pix_val   = have_r ? word : {8'h00, in_rx_byte};
          req.pix_col   = col_r;
          req.pix_row   = row_r;
          if (last) begin
            phase_nxt = PH_HUNT;
            have_nxt  = 1'b0;
            produce   = 1'b1;
            if (is_data) begin
              res_status    = tpmm_pkg::ST_DONE;
              req.zero_take = idx1_lt;
              req.zero_col  = col_inc;
              req.zero_row  = row_inc;
            end else begin
              res_status = tpmm_pkg::kind_status(ptype_r);
            end
          end
        end
        default: begin
          if (!have_r) begin
            low_nxt  = in_rx_byte;
            have_nxt = 1'b1;
          end else begin
            have_nxt = 1'b0;
            priority if (phase_r == PH_HUNT) begin
              if (word == tpmm_pkg::SYNC_WORD) begin
                phase_nxt = PH_TYPE;
              end
            end else if (phase_r == PH_TYPE) begin
              if (word > tpmm_pkg::TYPE_MAX) begin
                phase_nxt  = PH_HUNT;
                produce    = 1'b1;
                res_status = tpmm_pkg::ST_BAD_TYPE;
              end else begin
                ptype_nxt = word[1:0];
                phase_nxt = PH_LEN;
              end
            end else begin
              if (32'(word) > tpmm_pkg::MAX_LEN) begin
                phase_nxt  = PH_HUNT;
                produce    = 1'b1;
                res_status = tpmm_pkg::ST_BAD_LEN;
              end else begin
                left_nxt       = LEN_W'(word);
                idx_nxt        = '0;
                col_nxt        = '0;
                row_nxt        = '0;
                low_nxt        = '0;
                req.clr_centre = 1'b1;
                phase_nxt      = PH_BODY;
                if (word == 16'h0000) begin
                  phase_nxt = PH_HUNT;
                  produce   = 1'b1;
                  if (is_data) begin
                    res_status     = tpmm_pkg::ST_DONE;
                    req.zero_take  = 1'b1;
                    req.zero_first = 1'b1;
                  end else begin
                    res_status = tpmm_pkg::kind_status(ptype_r);
                  end
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      low_r   <= '0;
      have_r  <= 1'b0;
      ptype_r <= '0;
      left_r  <= '0;
      idx_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      have_r  <= have_nxt;
      ptype_r <= ptype_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // hold the result until taken; load a new one on the producing byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (produce) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      status_r <= res_status;
      res_r    <= (res_status == tpmm_pkg::ST_DONE) ? st_nxt : '0;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = status_r;
  assign out_max_temp   = res_r.hot_val;
  assign out_max_col    = 5'(res_r.hot_col);
  assign out_max_row    = 5'(res_r.hot_row);
  assign out_min_temp   = res_r.cold_val;
  assign out_min_col    = 5'(res_r.cold_col);
  assign out_min_row    = 5'(res_r.cold_row);
  assign out_center_sum = res_r.centre;

endmodule

`default_nettype wire

>>> hw/rtl/tpmm_checker.sv
// ----------------------------------------------------------------------------
// tpmm_checker
// Port-level checks of the thermal packet stats block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "thermal_packet_min_max_stats_macros.svh"

module tpmm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_rx_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_max_temp,
  input wire logic [4:0]  out_max_col,
  input wire logic [4:0]  out_max_row,
  input wire logic [15:0] out_min_temp,
  input wire logic [4:0]  out_min_col,
  input wire logic [4:0]  out_min_row,
  input wire logic [17:0] out_center_sum
);

  logic in_ok;
  logic stats_zero;

  assign in_ok      = (in_rx_byte == in_rx_byte);
  assign stats_zero = (out_max_temp == 16'h0) && (out_min_temp == 16'h0) &&
                      (out_max_col == 5'h0) && (out_min_col == 5'h0) &&
                      (out_center_sum == 18'h0);

  `TPMM_ASSERT(a_hold_result, (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
  `TPMM_ASSERT(a_status_range, out_valid |-> (out_status <= tpmm_pkg::ST_BAD_LEN))
  `TPMM_ASSERT(a_nonframe_zero, (out_valid && out_status != tpmm_pkg::ST_DONE) |-> stats_zero)
  `TPMM_ASSERT(a_row_range, (out_valid && out_status == tpmm_pkg::ST_DONE) |-> (32'(out_max_row) < tpmm_pkg::FRAME_HEIGHT && 32'(out_min_row) < tpmm_pkg::FRAME_HEIGHT))
  `TPMM_ASSERT(a_cause, $rose(out_valid) |-> $past(in_valid && in_ready && in_ok))

endmodule

bind thermal_packet_min_max_stats tpmm_checker u_tpmm_checker (.*);

`default_nettype wire
